// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tkb_pkg.sv =====
package tkb_pkg;

  localparam int VALUE_W = 12;
  localparam int SAMPLE_W = 16;
  localparam int RANK_W = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_OUT_W = 6;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISCARD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANK    = 2'd3;

  localparam logic [SAMPLE_W-1:0] INVALID_BITS = 16'hF000;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic {
    TKB_IDLE,
    TKB_RESP
  } tkb_state_t;

  typedef struct packed {
    logic               ins_up;
    logic               ins_down;
    logic [VALUE_W-1:0] value;
  } tkb_cmd_t;

endpackage

// ===== rtl/core/tkb_cell.sv =====
module tkb_cell
  import tkb_pkg::*;
(
  input  logic               clk,
  input  tkb_cmd_t           cmd,
  input  logic               cell_valid,
  input  logic [VALUE_W-1:0] left_entry,
  input  logic               left_lt,
  input  logic [VALUE_W-1:0] right_entry,
  input  logic               right_lt,
  output logic [VALUE_W-1:0] entry,
  output logic               lt
);

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;

  assign entry = entry_r;
  assign lt    = cell_valid && (entry_r < cmd.value);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_up) begin
      // make room: shift up from the left neighbor or take the new value
      if (!lt) begin
        entry_nxt = left_lt ? cmd.value : left_entry;
      end
    end else if (cmd.ins_down) begin
      // drop the smallest: shift down from the right neighbor
      if (right_lt) begin
        entry_nxt = right_entry;
      end else if (lt) begin
        entry_nxt = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/core/top_k_sorted_insert_buffer.sv =====
// Channel   Ports                                          Handshake
// request   in_action, in_sample_value, in_read_rank       start && !busy
// result    out_status, out_read_value, out_entry_count,   out_valid, one cycle
//           out_smallest, out_largest
// The cell row updates at the accepting edge and the result is shown in the
// following cycle, while busy is high.
// All cells compare and shift in parallel.
// rst_n is synchronous; it clears the count and the control state only.
// The receiver cannot stall; out_valid lasts exactly one cycle.
module top_k_sorted_insert_buffer
  import tkb_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_action,
  input  logic [SAMPLE_W-1:0]    in_sample_value,
  input  logic [RANK_W-1:0]      in_read_rank,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [VALUE_W-1:0]     out_read_value,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  output logic [VALUE_W-1:0]     out_smallest,
  output logic [VALUE_W-1:0]     out_largest
);

`include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RL = (DEPTH < 32) ? DEPTH : 32;

  tkb_state_t          state_r;
  tkb_state_t          state_nxt;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                act_r;
  logic [RANK_W-1:0]   rank_r;

  logic                accept;
  logic                full;
  logic                bad_value;
  logic [VALUE_W-1:0]  value;
  logic                rank_ok;
  tkb_cmd_t            cmd;

  logic [VALUE_W-1:0]  entry_w [DEPTH];
  logic [DEPTH-1:0]    lt_w;
  logic [DEPTH-1:0]    valid_w;

  logic [VALUE_W-1:0]  rd_value;
  logic [VALUE_W-1:0]  top_value;

  assign accept    = start && (state_r == TKB_IDLE);
  assign full      = (count_r == CW'(DEPTH));
  assign bad_value = |(in_sample_value & INVALID_BITS);
  assign value     = in_sample_value[VALUE_W-1:0];
  assign rank_ok   = ((CW + RANK_W)'(in_read_rank) < (CW + RANK_W)'(count_r));

  always_comb begin
    cmd.value    = value;
    cmd.ins_up   = 1'b0;
    cmd.ins_down = 1'b0;
    status_nxt   = status_r;
    count_nxt    = count_r;
    if (accept) begin
      if (in_action == ACT_READ) begin
        status_nxt = rank_ok ? ST_OK : ST_RANK;
      end else if (bad_value) begin
        status_nxt = ST_INVALID;
      end else if (!full) begin
        status_nxt = ST_OK;
        cmd.ins_up = 1'b1;
        count_nxt  = count_r + CW'(1);
      end else if (value <= entry_w[0]) begin
        status_nxt = ST_DISCARD;
      end else begin
        status_nxt   = ST_OK;
        cmd.ins_down = 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_W-1:0] left_entry;
      logic               left_lt;
      logic [VALUE_W-1:0] right_entry;
      logic               right_lt;

      assign valid_w[g] = (count_r > CW'(g));

      if (g == 0) begin : g_first
        assign left_entry = value;
        assign left_lt    = 1'b1;
      end else begin : g_mid_l
        assign left_entry = entry_w[g-1];
        assign left_lt    = lt_w[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign right_entry = '0;
        assign right_lt    = 1'b0;
      end else begin : g_mid_r
        assign right_entry = entry_w[g+1];
        assign right_lt    = lt_w[g+1];
      end

      tkb_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .cell_valid  (valid_w[g]),
        .left_entry  (left_entry),
        .left_lt     (left_lt),
        .right_entry (right_entry),
        .right_lt    (right_lt),
        .entry       (entry_w[g]),
        .lt          (lt_w[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TKB_IDLE: begin
        if (accept) begin
          state_nxt = TKB_RESP;
        end
      end
      TKB_RESP: begin
        state_nxt = TKB_IDLE;
      end
      default: begin
        state_nxt = TKB_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TKB_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (accept) begin
      act_r  <= in_action;
      rank_r <= in_read_rank;
    end
  end

  always_comb begin
    rd_value  = '0;
    top_value = '0;
    for (int i = 0; i < RL; i++) begin
      if (rank_r == RANK_W'(i)) begin
        rd_value = entry_w[i];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (valid_w[i] && ((i == DEPTH - 1) || !valid_w[(i + 1) % DEPTH])) begin
        top_value = top_value | entry_w[i];
      end
    end
  end

  assign busy            = (state_r == TKB_RESP);
  assign out_valid       = (state_r == TKB_RESP);
  assign out_status      = status_r;
  assign out_read_value  = ((act_r == ACT_READ) && (status_r == ST_OK)) ? rd_value : '0;
  assign out_entry_count = COUNT_OUT_W'(count_r);
  assign out_smallest    = valid_w[0] ? entry_w[0] : '0;
  assign out_largest     = top_value;

  `ASSERT_NEXT(a_one_cycle_result, out_valid, !out_valid,
               "result strobe held longer than one cycle")
  `ASSERT_NEXT(a_accept_gives_result, start && !busy, out_valid,
               "accepted request gave no result")
  `ASSERT_CLK(a_count_bound, count_r <= CW'(DEPTH), "entry count above depth")
  `ASSERT_CLK(a_value_zero, !out_valid || (out_status == ST_OK) || (out_read_value == '0),
              "read value not zero on a failed request")

endmodule
